// ----- sv/ccfp_pkg.sv -----
package ccfp_pkg;

  localparam int CW      = 24;
  localparam int UW      = CW + 1;
  localparam int SW      = 2 * CW + 2;
  localparam int DW      = 2 * CW + 3;
  localparam int NW      = 3 * CW + 3;
  localparam int N2W     = 3 * CW + 4;
  localparam int D2W     = 2 * CW + 3;
  localparam int NNW     = 2 * NW;
  localparam int DDW     = 2 * DW;
  localparam int RW      = 6 * CW + 9;
  localparam int QW      = CW + 2;
  localparam int NCELL   = QW;
  localparam int LIMB_W  = 32;

  typedef struct packed {
    logic signed [CW-1:0] point_a_x;
    logic signed [CW-1:0] point_a_y;
    logic signed [CW-1:0] point_b_x;
    logic signed [CW-1:0] point_b_y;
    logic signed [CW-1:0] point_c_x;
    logic signed [CW-1:0] point_c_y;
  } in_word_t;

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic [CW-1:0]        circle_radius;
    logic                 degenerate;
    logic                 overflow;
  } out_word_t;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic                 deg;
    logic                 neg_x;
    logic                 neg_y;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [N2W-1:0]  rem_x;
    logic [N2W-1:0]  rem_y;
    logic [D2W-1:0]  d2;
    logic [QW-1:0]   q_x;
    logic [QW-1:0]   q_y;
    logic [RW-1:0]   rad_rem;
    logic [RW-1:0]   rad_s;
    logic [DDW-1:0]  dd;
    logic [QW-1:0]   r;
  } cell_t;

endpackage

// ----- sv/ccfp_mul.sv -----
module ccfp_mul #(
  parameter int AW = 8,
  parameter int BW = 8
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int L  = ccfp_pkg::LIMB_W;
  localparam int LA = (AW + L - 1) / L;
  localparam int LB = (BW + L - 1) / L;
  localparam int MW = (LA + LB) * L;
  localparam int PW = AW + BW;

  logic [AW-1:0]   am;
  logic [BW-1:0]   bm;
  logic [LA*L-1:0] ae;
  logic [LB*L-1:0] be;
  logic [2*L-1:0]  pp_r [LA][LB];
  logic [MW-1:0]   row_r [LA];
  logic [MW-1:0]   row_nxt [LA];
  logic [MW-1:0]   sum_nxt;
  logic            neg1_r, neg2_r;
  logic [PW-1:0]   p_r;

  // sign and magnitude split
  always_comb begin
    am = a[AW-1] ? AW'(-a) : AW'(a);
    bm = b[BW-1] ? BW'(-b) : BW'(b);
    ae = (LA*L)'(am);
    be = (LB*L)'(bm);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LA; i++) begin
      for (int j = 0; j < LB; j++) begin
        pp_r[i][j] <= (2*L)'(ae[i*L +: L]) * (2*L)'(be[j*L +: L]);
      end
    end
    neg1_r <= a[AW-1] ^ b[BW-1];
  end

  always_comb begin
    for (int i = 0; i < LA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < LB; j++) begin
        row_nxt[i] = row_nxt[i] + (MW'(pp_r[i][j]) << ((i + j) * L));
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    neg2_r <= neg1_r;
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < LA; i++) begin
      sum_nxt = sum_nxt + row_r[i];
    end
  end

  always_ff @(posedge clk) begin
    p_r <= neg2_r ? PW'(-sum_nxt) : PW'(sum_nxt);
  end

  assign p = $signed(p_r);

endmodule

// ----- sv/ccfp_cell.sv -----
module ccfp_cell #(
  parameter int K = 0
) (
  input  logic            clk,
  input  ccfp_pkg::cell_t cell_in,
  output ccfp_pkg::cell_t cell_out
);

  ccfp_pkg::cell_t               cell_nxt;
  ccfp_pkg::cell_t               cell_r;
  logic [ccfp_pkg::N2W-1:0]      tdiv;
  logic [ccfp_pkg::RW-1:0]       dsh;
  logic [ccfp_pkg::RW-1:0]       troot;

  always_comb begin
    cell_nxt = cell_in;
    tdiv     = ccfp_pkg::N2W'(cell_in.d2) << K;
    dsh      = ccfp_pkg::RW'(cell_in.dd) << K;
    troot    = (cell_in.rad_s << (K + 1)) + (dsh << K);
    // one quotient bit for each centre lane
    if (cell_in.rem_x >= tdiv) begin
      cell_nxt.rem_x  = cell_in.rem_x - tdiv;
      cell_nxt.q_x[K] = 1'b1;
    end
    if (cell_in.rem_y >= tdiv) begin
      cell_nxt.rem_y  = cell_in.rem_y - tdiv;
      cell_nxt.q_y[K] = 1'b1;
    end
    // one radius bit: (r + 2^k)^2 * dd against the residual
    if (troot <= cell_in.rad_rem) begin
      cell_nxt.rad_rem = cell_in.rad_rem - troot;
      cell_nxt.rad_s   = cell_in.rad_s + dsh;
      cell_nxt.r[K]    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_out = cell_r;

endmodule

// ----- sv/circumcircle_from_three_points_core.sv -----
// channel   ports                       handshake
// input     start, busy, in_word        word taken when start is high and busy low
// result    out_strobe, out_word        word valid for the one cycle out_strobe is high
//
// one word accepted every cycle while busy is low; each result reaches the ports after
// the chain of 26 bit cells that form both centre quotients and the radius root, which
// follows the limb multiplier stages
// busy is high only while rst_n is low; reset clears the valid line, so no
// word in flight survives it
// the receiver cannot stall: every result is presented once and taken
module circumcircle_from_three_points_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ccfp_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output ccfp_pkg::out_word_t out_word
);

  localparam int CW    = ccfp_pkg::CW;
  localparam int UW    = ccfp_pkg::UW;
  localparam int SW    = ccfp_pkg::SW;
  localparam int DW    = ccfp_pkg::DW;
  localparam int NW    = ccfp_pkg::NW;
  localparam int QW    = ccfp_pkg::QW;
  localparam int NCELL = ccfp_pkg::NCELL;
  localparam int LAST  = 15 + NCELL;

  localparam logic signed [QW:0] SMAX = (QW+1)'(2 ** (CW - 1) - 1);
  localparam logic signed [QW:0] SMIN = -SMAX - (QW+1)'(1);

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [UW-1:0] ux;
    logic signed [UW-1:0] uy;
    logic signed [UW-1:0] vx;
    logic signed [UW-1:0] vy;
  } uv_t;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [DW-1:0] d;
  } mid_t;

  typedef struct packed {
    ccfp_pkg::side_t      side;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [DW-1:0] d;
  } norm_t;

  logic [LAST:1]                 vld_r;
  uv_t                           st1_nxt, st1_r;
  uv_t                           uvd_r [4];
  logic signed [2*UW-1:0]        p_uv, p_yx, p_xx, p_yy, p_vxx, p_vyy;
  logic signed [DW-1:0]          d5_r;
  logic signed [SW-1:0]          uu5_r, vv5_r;
  logic signed [NW-1:0]          p_a, p_b, p_c, p_e;
  mid_t                          md_r [3];
  logic signed [NW-1:0]          nx9_r, ny9_r;
  mid_t                          mid9_r;
  norm_t                         nrm_nxt;
  norm_t                         nrm_r [4];
  logic signed [ccfp_pkg::NNW-1:0] sq_x, sq_y;
  logic signed [ccfp_pkg::DDW-1:0] sq_d;
  logic signed [NW+1:0]          n2x, n2y;
  ccfp_pkg::cell_t               seed_nxt;
  ccfp_pkg::cell_t               chain [NCELL+1];
  ccfp_pkg::cell_t               fin;
  logic [CW:0]                   cx, cy;
  logic                          r_ov;
  ccfp_pkg::out_word_t           out_nxt, out_r;

  function automatic logic [CW:0] centre_fix(
    input logic signed [CW-1:0] base,
    input logic                 neg,
    input logic [QW-1:0]        q,
    input logic                 rem_nz
  );
    logic signed [QW:0] qi;
    logic signed [QW:0] sum;
    logic [CW:0]        res;
    qi  = (QW+1)'({1'b0, q}) + (QW+1)'(rem_nz);
    qi  = neg ? -qi : (QW+1)'({1'b0, q});
    sum = (QW+1)'(base) + qi;
    if (q[QW-1]) begin
      res = neg ? {1'b1, SMIN[CW-1:0]} : {1'b1, SMAX[CW-1:0]};
    end else if (sum > SMAX) begin
      res = {1'b1, SMAX[CW-1:0]};
    end else if (sum < SMIN) begin
      res = {1'b1, SMIN[CW-1:0]};
    end else begin
      res = {1'b0, sum[CW-1:0]};
    end
    return res;
  endfunction

  assign busy = ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAST-1:1], start & ~busy};
    end
  end

  // differences relative to the first point
  always_comb begin
    st1_nxt.ax = in_word.point_a_x;
    st1_nxt.ay = in_word.point_a_y;
    st1_nxt.ux = UW'(in_word.point_b_x) - UW'(in_word.point_a_x);
    st1_nxt.uy = UW'(in_word.point_b_y) - UW'(in_word.point_a_y);
    st1_nxt.vx = UW'(in_word.point_c_x) - UW'(in_word.point_a_x);
    st1_nxt.vy = UW'(in_word.point_c_y) - UW'(in_word.point_a_y);
  end

  always_ff @(posedge clk) begin
    st1_r    <= st1_nxt;
    uvd_r[0] <= st1_r;
    for (int i = 1; i < 4; i++) begin
      uvd_r[i] <= uvd_r[i-1];
    end
  end

  ccfp_mul #(.AW(UW), .BW(UW)) u_mul_uv  (.clk(clk), .a(st1_r.ux), .b(st1_r.vy), .p(p_uv));
  ccfp_mul #(.AW(UW), .BW(UW)) u_mul_yx  (.clk(clk), .a(st1_r.uy), .b(st1_r.vx), .p(p_yx));
  ccfp_mul #(.AW(UW), .BW(UW)) u_mul_xx  (.clk(clk), .a(st1_r.ux), .b(st1_r.ux), .p(p_xx));
  ccfp_mul #(.AW(UW), .BW(UW)) u_mul_yy  (.clk(clk), .a(st1_r.uy), .b(st1_r.uy), .p(p_yy));
  ccfp_mul #(.AW(UW), .BW(UW)) u_mul_vxx (.clk(clk), .a(st1_r.vx), .b(st1_r.vx), .p(p_vxx));
  ccfp_mul #(.AW(UW), .BW(UW)) u_mul_vyy (.clk(clk), .a(st1_r.vy), .b(st1_r.vy), .p(p_vyy));

  always_ff @(posedge clk) begin
    d5_r  <= (DW'(p_uv) - DW'(p_yx)) <<< 1;
    uu5_r <= SW'(p_xx) + SW'(p_yy);
    vv5_r <= SW'(p_vxx) + SW'(p_vyy);
  end

  ccfp_mul #(.AW(UW), .BW(SW)) u_mul_a (.clk(clk), .a(uvd_r[3].vy), .b(uu5_r), .p(p_a));
  ccfp_mul #(.AW(UW), .BW(SW)) u_mul_b (.clk(clk), .a(uvd_r[3].uy), .b(vv5_r), .p(p_b));
  ccfp_mul #(.AW(UW), .BW(SW)) u_mul_c (.clk(clk), .a(uvd_r[3].ux), .b(vv5_r), .p(p_c));
  ccfp_mul #(.AW(UW), .BW(SW)) u_mul_e (.clk(clk), .a(uvd_r[3].vx), .b(uu5_r), .p(p_e));

  always_ff @(posedge clk) begin
    md_r[0] <= '{ax: uvd_r[3].ax, ay: uvd_r[3].ay, d: d5_r};
    md_r[1] <= md_r[0];
    md_r[2] <= md_r[1];
    nx9_r   <= p_a - p_b;
    ny9_r   <= p_c - p_e;
    mid9_r  <= md_r[2];
  end

  // make the denominator positive
  always_comb begin
    nrm_nxt.side.ax    = mid9_r.ax;
    nrm_nxt.side.ay    = mid9_r.ay;
    nrm_nxt.side.deg   = (mid9_r.d == '0);
    nrm_nxt.side.neg_x = 1'b0;
    nrm_nxt.side.neg_y = 1'b0;
    nrm_nxt.nx = mid9_r.d[DW-1] ? -nx9_r : nx9_r;
    nrm_nxt.ny = mid9_r.d[DW-1] ? -ny9_r : ny9_r;
    nrm_nxt.d  = mid9_r.d[DW-1] ? -mid9_r.d : mid9_r.d;
  end

  always_ff @(posedge clk) begin
    nrm_r[0] <= nrm_nxt;
    for (int i = 1; i < 4; i++) begin
      nrm_r[i] <= nrm_r[i-1];
    end
  end

  ccfp_mul #(.AW(NW), .BW(NW)) u_sq_x (.clk(clk), .a(nrm_r[0].nx), .b(nrm_r[0].nx), .p(sq_x));
  ccfp_mul #(.AW(NW), .BW(NW)) u_sq_y (.clk(clk), .a(nrm_r[0].ny), .b(nrm_r[0].ny), .p(sq_y));
  ccfp_mul #(.AW(DW), .BW(DW)) u_sq_d (.clk(clk), .a(nrm_r[0].d), .b(nrm_r[0].d), .p(sq_d));

  // rounded centre numerators 2n + d over 2d
  always_comb begin
    n2x = ((NW+2)'(nrm_r[3].nx) <<< 1) + (NW+2)'(nrm_r[3].d);
    n2y = ((NW+2)'(nrm_r[3].ny) <<< 1) + (NW+2)'(nrm_r[3].d);
    seed_nxt            = '0;
    seed_nxt.side       = nrm_r[3].side;
    seed_nxt.side.neg_x = n2x[NW+1];
    seed_nxt.side.neg_y = n2y[NW+1];
    seed_nxt.rem_x      = ccfp_pkg::N2W'(n2x[NW+1] ? -n2x : n2x);
    seed_nxt.rem_y      = ccfp_pkg::N2W'(n2y[NW+1] ? -n2y : n2y);
    seed_nxt.d2         = ccfp_pkg::D2W'(nrm_r[3].d) << 1;
    seed_nxt.rad_rem    = ccfp_pkg::RW'(sq_x) + ccfp_pkg::RW'(sq_y);
    seed_nxt.dd         = ccfp_pkg::DDW'(sq_d);
  end

  always_ff @(posedge clk) begin
    chain[0] <= seed_nxt;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ccfp_cell #(.K(QW - 1 - i)) u_cell (
      .clk     (clk),
      .cell_in (chain[i]),
      .cell_out(chain[i+1])
    );
  end

  always_comb begin
    fin  = chain[NCELL];
    cx   = centre_fix(fin.side.ax, fin.side.neg_x, fin.q_x, fin.rem_x != '0);
    cy   = centre_fix(fin.side.ay, fin.side.neg_y, fin.q_y, fin.rem_y != '0);
    r_ov = |fin.r[QW-1:CW];
    if (fin.side.deg) begin
      out_nxt            = '0;
      out_nxt.degenerate = 1'b1;
    end else begin
      out_nxt.center_x      = cx[CW-1:0];
      out_nxt.center_y      = cy[CW-1:0];
      out_nxt.circle_radius = r_ov ? '1 : fin.r[CW-1:0];
      out_nxt.degenerate    = 1'b0;
      out_nxt.overflow      = cx[CW] | cy[CW] | r_ov;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_word   = out_r;
  assign out_strobe = vld_r[LAST];

endmodule
